/* sv/odd_permanent_partition_search_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the odd permanent partition search unit
// Implication checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ODD_PERMANENT_PARTITION_SEARCH_UNIT_MACROS_SVH
`define ODD_PERMANENT_PARTITION_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define OPPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OPPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/opps_pkg.sv */
// ----------------------------------------------------------------------------
// opps_pkg
// Shared types and constants for the odd permanent partition search unit.
// ----------------------------------------------------------------------------
package opps_pkg;

   localparam int MAX_PARTS_DEF   = 4;
   localparam int TOTAL_WIDTH_DEF = 8;

   // result status codes
   localparam logic [1:0] STATUS_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_NONE   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   typedef struct packed {
      logic [7:0] total;
      logic [2:0] part_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] part_a;
      logic [7:0] part_b;
      logic [7:0] part_c;
      logic [7:0] part_d;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VISIT,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic start;     // load a new request
      logic visit;     // test parity, then step H3 or enter the scan
      logic scan;      // one step of the H4 scan or the H5 fix-up
      logic load_rsp;  // move the result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_reject;  // request on the port is out of range
      logic h3_ok;       // simple step p0--, p1++ is possible
      logic scan_end;    // scan ran past the last part: walk finished
      logic scan_ge;     // scanned part still at or above the limit
      logic rsp_free;    // output register can take a result
   } dp_status_type;

endpackage

/* sv/odd_permanent_partition_search_unit.sv */
// ----------------------------------------------------------------------------
// odd_permanent_partition_search_unit
// Walks all partitions of a total into 2..4 parts, reports the last odd one.
// ----------------------------------------------------------------------------
// Sequence: a rejected item goes straight to the hand-off; otherwise P
//   partitions are visited (one per cycle) and, each time the simple step
//   fails, the H4 scan takes one to three steps; then comes the hand-off.
// Throughput: one item at a time, the next taken the cycle after the hand-off;
//   for four parts P is about total^3 / 144, set by the visit/scan loop.
// Reset: synchronous, active high; clears the sequencer, the walk state and
//   the output register.
// ----------------------------------------------------------------------------
`include "odd_permanent_partition_search_unit_macros.svh"

module odd_permanent_partition_search_unit
   import opps_pkg::*;
#(
   parameter int MAX_PARTS   = MAX_PARTS_DEF,   // 2..4
   parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF  // 4..16
)
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Controller and datapath talk only through the command and status groups.
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Sequencer: idle -> visit <-> scan -> done -> idle; a reject jumps to done.
   // A new item is taken only in idle; the output register lets a finished item
   // wait for the receiver while the next one is already being searched.
   opps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Holds the partition being visited, the last odd one, the H4 running
   // sum and scan index, and the output register.
   opps_datapath #(
      .MAX_PARTS   (MAX_PARTS),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   logic rsp_found;
   logic parts_zero;
   logic parts_ordered;

   assign rsp_found     = rsp_valid && (rsp_data.status == STATUS_FOUND);
   assign parts_zero    = (rsp_data.part_a == 8'd0) && (rsp_data.part_b == 8'd0)
                        && (rsp_data.part_c == 8'd0) && (rsp_data.part_d == 8'd0);
   assign parts_ordered = (rsp_data.part_a >= rsp_data.part_b)
                        && (rsp_data.part_b >= rsp_data.part_c)
                        && (rsp_data.part_c >= rsp_data.part_d);

   // after taking an item the block is busy until its result is loaded
   `OPPS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "busy not held")

   // no part is reported unless an odd partition was found
   `OPPS_ASSERT_NOW(a_zero_parts, rsp_valid && !rsp_found, parts_zero, "parts set without a find")

   // a found partition keeps its parts in non-increasing order
   `OPPS_ASSERT_NOW(a_order, rsp_found, parts_ordered, "found partition out of order")

endmodule

/* sv/opps_ctrl.sv */
// ----------------------------------------------------------------------------
// opps_ctrl
// Sequencer for the partition walk: idle, visit, scan and result hand-off.
// ----------------------------------------------------------------------------
module opps_ctrl
   import opps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = dp_status.req_reject ? ST_DONE : ST_VISIT;
            end
         end
         ST_VISIT: begin
            cmd.visit = 1'b1;
            if (!dp_status.h3_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (dp_status.scan_end) begin
               state_in = ST_DONE;
            end else if (!dp_status.scan_ge) begin
               state_in = ST_VISIT;
            end
         end
         ST_DONE: begin
            if (dp_status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/opps_datapath.sv */
// ----------------------------------------------------------------------------
// opps_datapath
// Partition registers, H4 scan logic, parity test and output register.
// ----------------------------------------------------------------------------
module opps_datapath
   import opps_pkg::*;
#(
   parameter int MAX_PARTS   = MAX_PARTS_DEF,
   parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int TW     = TOTAL_WIDTH;
   localparam int IDX_W  = (MAX_PARTS > 2) ? $clog2(MAX_PARTS) : 1;
   localparam int SCAN_W = $clog2(MAX_PARTS + 1);

   logic [TW-1:0]   parts_ff  [MAX_PARTS];
   logic [TW-1:0]   parts_in  [MAX_PARTS];
   logic [TW-1:0]   chosen_ff [MAX_PARTS];
   logic [TW-1:0]   chosen_in [MAX_PARTS];
   logic [TW:0]     carry_ff;
   logic [TW:0]     carry_in;
   logic [SCAN_W-1:0] scan_ff;
   logic [SCAN_W-1:0] scan_in;
   logic            found_ff;
   logic            found_in;
   logic [2:0]      cnt_ff;
   logic [2:0]      cnt_in;
   logic            reject_ff;
   logic            reject_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   // request decode
   logic [TW+7:0]   total_ext;
   logic [TW-1:0]   req_total;
   logic [2:0]      req_cnt;
   logic [TW-1:0]   first_part;

   assign total_ext  = {{TW{1'b0}}, req_data.total};
   assign req_total  = total_ext[TW-1:0];
   assign req_cnt    = req_data.part_count;
   assign first_part = req_total - TW'(req_cnt) + TW'(1);

   assign dp_status.req_reject = (req_cnt < 3'd2) || (req_cnt > 3'd4)
                               || ({1'b0, req_cnt} > 4'(MAX_PARTS))
                               || (req_total < TW'(req_cnt));

   // parity of the circulant permanent from the part low bits
   logic [3:0] lsb;
   logic       odd;

   for (genvar k = 0; k < 4; k++) begin : g_lsb
      if (k < MAX_PARTS) begin : g_on
         assign lsb[k] = parts_ff[k][0] & (3'(k) < cnt_ff);
      end else begin : g_off
         assign lsb[k] = 1'b0;
      end
   end

   assign odd = (^lsb) ^ ((cnt_ff == 3'd3) & (&lsb[2:0]));

   // H3 test and H4 scan
   logic [TW-1:0] p0;
   logic [TW-1:0] p1;
   logic [TW-1:0] pj;
   logic [TW-1:0] x_next;
   logic [TW:0]   fix_carry;

   assign p0 = parts_ff[0];
   assign p1 = parts_ff[1];
   assign pj = parts_ff[scan_ff[IDX_W-1:0]];
   assign x_next = pj + TW'(1);

   assign dp_status.h3_ok    = ({1'b0, p1} + (TW+1)'(1)) < {1'b0, p0};
   assign dp_status.scan_end = 4'(scan_ff) >= 4'(cnt_ff);
   assign dp_status.scan_ge  = pj >= (p0 - TW'(1));
   assign dp_status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fix_carry = carry_ff;
      for (int i = 1; i < MAX_PARTS; i++) begin
         if (SCAN_W'(i) < scan_ff) begin
            fix_carry = fix_carry - {1'b0, x_next};
         end
      end
   end

   // output part widening or trimming to 8 bits
   logic [7:0] out_part [4];

   for (genvar k = 0; k < 4; k++) begin : g_out
      if (k < MAX_PARTS) begin : g_on
         logic [TW+7:0] ext;
         assign ext         = {8'b0, chosen_ff[k]};
         assign out_part[k] = found_ff ? ext[7:0] : 8'd0;
      end else begin : g_off
         assign out_part[k] = 8'd0;
      end
   end

   always_comb begin
      parts_in     = parts_ff;
      chosen_in    = chosen_ff;
      carry_in     = carry_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      reject_in    = reject_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.start) begin
         cnt_in    = req_cnt;
         reject_in = dp_status.req_reject;
         found_in  = 1'b0;
         carry_in  = '0;
         scan_in   = '0;
         for (int i = 0; i < MAX_PARTS; i++) begin
            chosen_in[i] = '0;
            if (i == 0) begin
               parts_in[i] = first_part;
            end else begin
               parts_in[i] = (3'(i) < req_cnt) ? TW'(1) : '0;
            end
         end
      end

      if (cmd.visit) begin
         if (odd) begin
            chosen_in = parts_ff;
            found_in  = 1'b1;
         end
         if (dp_status.h3_ok) begin
            parts_in[0] = p0 - TW'(1);
            parts_in[1] = p1 + TW'(1);
         end else begin
            carry_in = {1'b0, p0} + {1'b0, p1} - (TW+1)'(1);
            scan_in  = SCAN_W'(2);
         end
      end

      if (cmd.scan && !dp_status.scan_end) begin
         if (dp_status.scan_ge) begin
            carry_in = carry_ff + {1'b0, pj};
            scan_in  = scan_ff + SCAN_W'(1);
         end else begin
            for (int i = 1; i < MAX_PARTS; i++) begin
               if (SCAN_W'(i) <= scan_ff) begin
                  parts_in[i] = x_next;
               end
            end
            parts_in[0] = fix_carry[TW-1:0];
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (reject_ff) begin
            rsp_in.status = STATUS_REJECT;
         end else if (found_ff) begin
            rsp_in.status = STATUS_FOUND;
         end else begin
            rsp_in.status = STATUS_NONE;
         end
         rsp_in.part_a = out_part[0];
         rsp_in.part_b = out_part[1];
         rsp_in.part_c = out_part[2];
         rsp_in.part_d = out_part[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_ff  <= '{default: '0};
         chosen_ff <= '{default: '0};
         carry_ff  <= '0;
         scan_ff   <= '0;
         found_ff  <= 1'b0;
         cnt_ff    <= '0;
         reject_ff <= 1'b0;
         rsp_ff    <= '0;
      end else begin
         parts_ff  <= parts_in;
         chosen_ff <= chosen_in;
         carry_ff  <= carry_in;
         scan_ff   <= scan_in;
         found_ff  <= found_in;
         cnt_ff    <= cnt_in;
         reject_ff <= reject_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
